>>> rtl/core/cba_pkg.sv
// Package with constants, codes and types for the chained block allocator.
package cba_pkg;

  localparam int NUM_BLOCKS  = 64;
  localparam int BLOCK_BYTES = 4096;
  localparam int IDX_W       = 6;
  localparam int LINK_W      = 7;
  localparam int CNT_W       = 7;
  localparam int FILL_W      = 13;
  localparam int FREE_W      = 19;
  localparam int BYTES_W     = 24;
  localparam int SHIFT_W     = 12;
  localparam logic [LINK_W-1:0] END_LINK = 7'd127;
  localparam logic [FREE_W-1:0] TOTAL_BYTES = FREE_W'(NUM_BLOCKS * BLOCK_BYTES);

  typedef enum logic [1:0] {
    KIND_ALLOC  = 2'd0,
    KIND_FREE   = 2'd1,
    KIND_LOOKUP = 2'd2,
    KIND_NONE   = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_DUP     = 2'd1,
    ST_NOSPACE = 2'd2,
    ST_NOTFND  = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    BLK_FREE  = 2'd0,
    BLK_START = 2'd1,
    BLK_NEXT  = 2'd2
  } blk_t;

  // One word of the block table.
  typedef struct packed {
    blk_t              stat;
    logic [LINK_W-1:0] link;
    logic [31:0]       key;
    logic [FILL_W-1:0] fill;
  } entry_t;

  // One result transaction.
  typedef struct packed {
    status_t           status;
    logic [IDX_W-1:0]  idx;
    logic [FILL_W-1:0] fill;
    logic [CNT_W-1:0]  freed;
    logic [FREE_W-1:0] free_now;
    logic [CNT_W-1:0]  files_now;
    logic              last;
  } result_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN,
    S_SCAN_WAIT,
    S_DECIDE,
    S_PICK,
    S_PICK_WAIT,
    S_CLOSE,
    S_WALK,
    S_WALK_WAIT,
    S_OUT
  } state_t;

endpackage

>>> rtl/core/chained_block_allocator.sv
// Top level of the chained block allocator: table memory and request sequencer.
//
//   Channel | Ports                                               | Direction
//   input   | in_valid in_ready in_kind in_file_key in_file_bytes | into the block
//   result  | out_valid out_ready out_status out_block_index out_block_fill
//           | out_blocks_freed out_free_bytes_now out_file_count_now out_last | out of the block
//
// One transaction is handled at a time; in_ready is high only while the sequencer is idle.
// Every request first scans the whole table, one block at a time through the registered
// memory read port, so even a rejected request waits for the full scan. An allocate then
// reads blocks until it has picked enough free ones, with one result per picked block and
// one closing write; free walks the chain blocks and reports once, and lookup reports one
// result per chain block. A stalled result holds the sequencer until it is taken.
// After reset a clearing pass over all NUM_BLOCKS blocks marks every block free, with in_ready low.
module chained_block_allocator (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_kind,
  input  logic [31:0] in_file_key,
  input  logic [23:0] in_file_bytes,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_status,
  output logic [5:0]  out_block_index,
  output logic [12:0] out_block_fill,
  output logic [6:0]  out_blocks_freed,
  output logic [18:0] out_free_bytes_now,
  output logic [6:0]  out_file_count_now,
  output logic        out_last
);

  localparam int IW = cba_pkg::IDX_W;
  localparam int LW = cba_pkg::LINK_W;
  localparam int CW = cba_pkg::CNT_W;
  localparam int FW = cba_pkg::FILL_W;
  localparam int RW = cba_pkg::FREE_W;
  localparam int BW = cba_pkg::BYTES_W;
  localparam int NW = cba_pkg::BYTES_W - cba_pkg::SHIFT_W + 1;

  // The whole block table lives in one memory with a registered read port.
  cba_pkg::entry_t tbl_mem [cba_pkg::NUM_BLOCKS];

  logic [IW-1:0]   rd_addr;
  cba_pkg::entry_t rd_q;
  logic            wr_en;
  logic [IW-1:0]   wr_addr;
  cba_pkg::entry_t wr_data;

  cba_pkg::state_t state_r, state_nxt;
  cba_pkg::state_t ret_r, ret_c;   // where the sequencer resumes after a result
  logic [1:0]    kind_r;
  logic [31:0]   key_r;
  logic [BW-1:0] bytes_r;
  logic [CW-1:0] ptr_r;            // table position during clearing, scan and pick
  logic          found_r;
  logic [IW-1:0] start_r;
  logic [CW-1:0] nfree_r;
  logic [CW-1:0] need_r;
  logic [CW-1:0] done_r;           // blocks already picked or walked
  logic [IW-1:0] prev_r;           // last picked block, written once its successor is known
  logic [FW-1:0] prev_fill_r;
  logic [IW-1:0] cur_r;
  logic [RW-1:0] free_r;
  logic [CW-1:0] files_r;
  logic          out_valid_r;
  cba_pkg::result_t res_r, res_c;
  logic          load_res;

  logic [BW:0]   round_c;
  logic [NW-1:0] need_c;
  logic          nospace_c;
  logic          alloc_ok_c;
  logic          last_ptr_c;
  logic          last_pick_c;
  logic [FW-1:0] fill_c;
  cba_pkg::blk_t prev_stat_c;
  logic [CW-1:0] cnt_c;
  logic          walk_end_c;
  logic [RW-1:0] free_sum_c;
  logic [CW-1:0] files_dec_c;

  // Block count of the request: a zero-length file still takes one block.
  assign round_c = {1'b0, bytes_r} + (BW + 1)'(cba_pkg::BLOCK_BYTES - 1);
  assign need_c  = (bytes_r == '0) ? NW'(1) : round_c[BW:cba_pkg::SHIFT_W];

  assign nospace_c  = (BW'(free_r) < bytes_r) || (need_c > NW'(nfree_r));
  assign alloc_ok_c = (kind_r == cba_pkg::KIND_ALLOC) && !found_r && !nospace_c;
  assign last_ptr_c = (ptr_r == CW'(cba_pkg::NUM_BLOCKS - 1));

  // The last block of a file holds the remainder, the others are full.
  assign last_pick_c = (done_r + CW'(1) == need_r);
  assign fill_c      = last_pick_c ?
      FW'(bytes_r - (BW'(done_r) << cba_pkg::SHIFT_W)) : FW'(cba_pkg::BLOCK_BYTES);
  assign prev_stat_c = (done_r == CW'(1)) ? cba_pkg::BLK_START : cba_pkg::BLK_NEXT;

  // A walk ends at a link outside the table or after a full table of blocks.
  assign cnt_c       = done_r + CW'(1);
  assign walk_end_c  = (rd_q.link >= LW'(cba_pkg::NUM_BLOCKS)) ||
                       (cnt_c == CW'(cba_pkg::NUM_BLOCKS));
  assign free_sum_c  = free_r + (RW'(cnt_c) << cba_pkg::SHIFT_W);
  assign files_dec_c = (files_r == '0) ? '0 : files_r - CW'(1);

  always_ff @(posedge clk) begin
    if (wr_en) tbl_mem[wr_addr] <= wr_data;
    rd_q <= tbl_mem[rd_addr];
  end

  assign in_ready           = (state_r == cba_pkg::S_IDLE);
  assign out_valid          = out_valid_r;
  assign out_status         = res_r.status;
  assign out_block_index    = res_r.idx;
  assign out_block_fill     = res_r.fill;
  assign out_blocks_freed   = res_r.freed;
  assign out_free_bytes_now = res_r.free_now;
  assign out_file_count_now = res_r.files_now;
  assign out_last           = res_r.last;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= cba_pkg::S_CLEAR;
    else state_r <= state_nxt;
  end

  // Next state, memory port control and the result to be loaded.
  always_comb begin
    state_nxt          = state_r;
    rd_addr            = ptr_r[IW-1:0];
    wr_en              = 1'b0;
    wr_addr            = prev_r;
    wr_data            = '0;
    load_res           = 1'b0;
    ret_c              = cba_pkg::S_IDLE;
    res_c              = '0;
    res_c.status       = cba_pkg::ST_OK;
    res_c.free_now     = free_r;
    res_c.files_now    = files_r;
    unique case (state_r)
      cba_pkg::S_CLEAR: begin
        wr_en        = 1'b1;
        wr_addr      = ptr_r[IW-1:0];
        wr_data.stat = cba_pkg::BLK_FREE;
        wr_data.link = cba_pkg::END_LINK;
        if (last_ptr_c) state_nxt = cba_pkg::S_IDLE;
      end
      cba_pkg::S_IDLE: begin
        if (in_valid && in_kind != cba_pkg::KIND_NONE) state_nxt = cba_pkg::S_SCAN;
      end
      cba_pkg::S_SCAN:      state_nxt = cba_pkg::S_SCAN_WAIT;
      cba_pkg::S_SCAN_WAIT: state_nxt = last_ptr_c ? cba_pkg::S_DECIDE : cba_pkg::S_SCAN;
      cba_pkg::S_DECIDE: begin
        // Rejected requests report once with the state left as it was.
        res_c.last = 1'b1;
        if (kind_r == cba_pkg::KIND_ALLOC) begin
          if (found_r) begin
            res_c.status = cba_pkg::ST_DUP;
            load_res     = 1'b1;
            state_nxt    = cba_pkg::S_OUT;
          end else if (nospace_c) begin
            res_c.status = cba_pkg::ST_NOSPACE;
            load_res     = 1'b1;
            state_nxt    = cba_pkg::S_OUT;
          end else begin
            state_nxt = cba_pkg::S_PICK;
          end
        end else if (!found_r) begin
          res_c.status = cba_pkg::ST_NOTFND;
          load_res     = 1'b1;
          state_nxt    = cba_pkg::S_OUT;
        end else begin
          state_nxt = cba_pkg::S_WALK;
        end
      end
      cba_pkg::S_PICK:      state_nxt = cba_pkg::S_PICK_WAIT;
      cba_pkg::S_PICK_WAIT: begin
        if (rd_q.stat == cba_pkg::BLK_FREE) begin
          // The previous block now learns its successor.
          wr_en        = (done_r != '0);
          wr_addr      = prev_r;
          wr_data.stat = prev_stat_c;
          wr_data.link = LW'(ptr_r[IW-1:0]);
          wr_data.key  = key_r;
          wr_data.fill = prev_fill_r;
          load_res     = 1'b1;
          res_c.idx    = ptr_r[IW-1:0];
          res_c.fill   = fill_c;
          res_c.last   = last_pick_c;
          ret_c        = last_pick_c ? cba_pkg::S_CLOSE : cba_pkg::S_PICK;
          state_nxt    = cba_pkg::S_OUT;
        end else begin
          state_nxt = cba_pkg::S_PICK;
        end
      end
      cba_pkg::S_CLOSE: begin
        // The final block of the chain ends the link list.
        wr_en        = 1'b1;
        wr_addr      = prev_r;
        wr_data.stat = prev_stat_c;
        wr_data.link = cba_pkg::END_LINK;
        wr_data.key  = key_r;
        wr_data.fill = prev_fill_r;
        state_nxt    = cba_pkg::S_IDLE;
      end
      cba_pkg::S_WALK: begin
        rd_addr   = cur_r;
        state_nxt = cba_pkg::S_WALK_WAIT;
      end
      cba_pkg::S_WALK_WAIT: begin
        if (kind_r == cba_pkg::KIND_FREE) begin
          wr_en        = 1'b1;
          wr_addr      = cur_r;
          wr_data      = rd_q;
          wr_data.stat = cba_pkg::BLK_FREE;
          if (walk_end_c) begin
            load_res        = 1'b1;
            res_c.idx       = start_r;
            res_c.freed     = cnt_c;
            res_c.free_now  = free_sum_c;
            res_c.files_now = files_dec_c;
            res_c.last      = 1'b1;
            state_nxt       = cba_pkg::S_OUT;
          end else begin
            state_nxt = cba_pkg::S_WALK;
          end
        end else begin
          load_res   = 1'b1;
          res_c.idx  = cur_r;
          res_c.fill = rd_q.fill;
          res_c.last = walk_end_c;
          ret_c      = walk_end_c ? cba_pkg::S_IDLE : cba_pkg::S_WALK;
          state_nxt  = cba_pkg::S_OUT;
        end
      end
      cba_pkg::S_OUT: begin
        if (out_ready) state_nxt = ret_r;
      end
      default: state_nxt = cba_pkg::S_IDLE;
    endcase
  end

  // Datapath registers of the sequencer.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ptr_r       <= '0;
      free_r      <= cba_pkg::TOTAL_BYTES;
      files_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (load_res) begin
        res_r       <= res_c;
        ret_r       <= ret_c;
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        cba_pkg::S_CLEAR: ptr_r <= ptr_r + CW'(1);
        cba_pkg::S_IDLE: begin
          if (in_valid) begin
            kind_r  <= in_kind;
            key_r   <= in_file_key;
            bytes_r <= in_file_bytes;
            ptr_r   <= '0;
            found_r <= 1'b0;
            nfree_r <= '0;
          end
        end
        cba_pkg::S_SCAN_WAIT: begin
          if (rd_q.stat == cba_pkg::BLK_FREE) nfree_r <= nfree_r + CW'(1);
          // The lowest start block with a matching key heads the file.
          if (!found_r && rd_q.stat == cba_pkg::BLK_START && rd_q.key == key_r) begin
            found_r <= 1'b1;
            start_r <= ptr_r[IW-1:0];
          end
          ptr_r <= ptr_r + CW'(1);
        end
        cba_pkg::S_DECIDE: begin
          ptr_r  <= '0;
          done_r <= '0;
          cur_r  <= start_r;
          need_r <= need_c[CW-1:0];
          if (alloc_ok_c) begin
            free_r  <= free_r - (RW'(need_c[CW-1:0]) << cba_pkg::SHIFT_W);
            files_r <= files_r + CW'(1);
          end
        end
        cba_pkg::S_PICK_WAIT: begin
          ptr_r <= ptr_r + CW'(1);
          if (rd_q.stat == cba_pkg::BLK_FREE) begin
            prev_r      <= ptr_r[IW-1:0];
            prev_fill_r <= fill_c;
            done_r      <= cnt_c;
          end
        end
        cba_pkg::S_WALK_WAIT: begin
          done_r <= cnt_c;
          cur_r  <= rd_q.link[IW-1:0];
          if (kind_r == cba_pkg::KIND_FREE && walk_end_c) begin
            free_r  <= free_sum_c;
            files_r <= files_dec_c;
          end
        end
        default: ;
      endcase
    end
  end

endmodule
